### rtl/sm4cbc_pkg.sv
// ----------------------------------------------------------------------------
// sm4cbc_pkg
// Shared constants, register indexes and cipher helper functions for the
// SM4 CBC cipher unit.
// ----------------------------------------------------------------------------
package sm4cbc_pkg;

  localparam int ROUND_COUNT = 32;
  localparam int BLOCK_W     = 128;
  localparam int HALF_W      = 64;
  localparam int WORD_W      = 32;
  localparam int CFG_IDX_W   = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IV_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IV_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd4;

  localparam logic DIR_ENCRYPT = 1'b0;
  localparam logic DIR_DECRYPT = 1'b1;

  // Family key, words zero to three packed from the top
  localparam logic [BLOCK_W-1:0] FK = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

  localparam logic [7:0] SBOX [0:255] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  // Byte-wise S-box substitution of one word
  function automatic logic [WORD_W-1:0] sm4_tau(input logic [WORD_W-1:0] v);
    sm4_tau = {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  // Key schedule constant: byte j of word i is (4i+j)*7 mod 256
  function automatic logic [WORD_W-1:0] ck_word(input logic [7:0] i);
    logic [WORD_W-1:0] w;
    logic [7:0]        b;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      b = 8'(({i, 2'b00} + 10'(j)) * 10'd7);
      w = {w[23:0], b};
    end
    ck_word = w;
  endfunction

endpackage

### rtl/sm4cbc_blk_in_if.sv
// ----------------------------------------------------------------------------
// sm4cbc_blk_in_if
// Input block channel: valid/ready with two 64-bit halves and a chain-start flag.
// ----------------------------------------------------------------------------
interface sm4cbc_blk_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] in_high;
  logic [63:0] in_low;
  logic        first_block;

  modport source (output valid, output in_high, output in_low, output first_block,
                  input ready);
  modport sink   (input valid, input in_high, input in_low, input first_block,
                  output ready);
endinterface

### rtl/sm4cbc_blk_out_if.sv
// ----------------------------------------------------------------------------
// sm4cbc_blk_out_if
// Result block channel: valid/ready with two 64-bit halves.
// ----------------------------------------------------------------------------
interface sm4cbc_blk_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_high;
  logic [63:0] out_low;

  modport source (output valid, output out_high, output out_low, input ready);
  modport sink   (input valid, input out_high, input out_low, output ready);
endinterface

### rtl/sm4cbc_cfg_if.sv
// ----------------------------------------------------------------------------
// sm4cbc_cfg_if
// Configuration write channel: valid/ready with register index and write data.
// ----------------------------------------------------------------------------
interface sm4cbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/sm4cbc_ram.sv
// ----------------------------------------------------------------------------
// sm4cbc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sm4cbc_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/sm4cbc_round.sv
// ----------------------------------------------------------------------------
// sm4cbc_round
// One SM4 round, shared by the key schedule and the data path.
// ----------------------------------------------------------------------------
module sm4cbc_round (
  input  logic [127:0] words,     // word zero in the top bits
  input  logic [31:0]  rk,
  input  logic [7:0]   round_idx,
  input  logic         key_mode,
  output logic [31:0]  nx
);

  logic [31:0] w0, mix, t, lin;

  always_comb begin
    w0  = words[127:96];
    // key schedule mixes in the CK constant, data rounds the round key
    mix = words[95:64] ^ words[63:32] ^ words[31:0] ^
          (key_mode ? sm4cbc_pkg::ck_word(round_idx) : rk);
    t   = sm4cbc_pkg::sm4_tau(mix);
    if (key_mode) begin
      lin = t ^ {t[18:0], t[31:19]} ^ {t[8:0], t[31:9]};
    end else begin
      lin = t ^ {t[29:0], t[31:30]} ^ {t[21:0], t[31:22]} ^
            {t[13:0], t[31:14]} ^ {t[7:0], t[31:8]};
    end
    nx = w0 ^ lin;
  end

endmodule

### rtl/sm4_cbc_cipher_unit.sv
// ----------------------------------------------------------------------------
// sm4_cbc_cipher_unit
// Sequence: with round keys ready, an accepted input beat passes S_LOAD (first
//   round-key read), S_ROUND and S_FINISH, which loads the output register; the
//   first block after reset or a key write runs key expansion (S_EXPAND) first.
// Throughput: one block at a time, set by the single round unit and the one
//   round-key read per round from the key RAM; input waits for S_IDLE again.
// Reset: synchronous, active high; clears config, control, chain, key-valid flag.
// ----------------------------------------------------------------------------
module sm4_cbc_cipher_unit #(
  parameter int ROUND_COUNT = sm4cbc_pkg::ROUND_COUNT
) (
  input  logic              clk,
  input  logic              rst,
  sm4cbc_blk_in_if.sink     in_blk,
  sm4cbc_blk_out_if.source  out_blk,
  sm4cbc_cfg_if.sink        cfg
);

  localparam int CNT_W = $clog2(ROUND_COUNT);
  localparam logic [CNT_W-1:0] LAST_ROUND = CNT_W'(ROUND_COUNT - 1);

  // Controller states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXPAND = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_ROUND  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]   state;

  // Configuration registers
  logic [63:0]  key_high, key_low, iv_high, iv_low;
  logic         direction;
  logic         keys_valid;

  // Chain value: last ciphertext block
  logic [63:0]  chain_high, chain_low;

  // Working registers
  logic [127:0] x_words;     // data state, word zero on top
  logic [127:0] k_words;     // key schedule state
  logic [127:0] mask;        // post-whitening for decryption
  logic [CNT_W-1:0] cnt;

  logic         out_valid;
  logic [63:0]  out_high, out_low;

  // Round key RAM
  logic             rk_we;
  logic [CNT_W-1:0] rk_raddr;
  logic [31:0]      rk_rdata;
  logic [CNT_W-1:0] rd_step;

  // Shared round unit
  logic             key_mode;
  logic [127:0]     rnd_words;
  logic [31:0]      nx;

  logic             in_beat;
  logic [63:0]      ch, cl;
  logic [127:0]     result;
  logic             out_free;

  assign in_blk.ready     = (state == S_IDLE);
  assign in_beat          = in_blk.valid && in_blk.ready;
  assign cfg.ready        = (state == S_IDLE);
  assign out_blk.valid    = out_valid;
  assign out_blk.out_high = out_high;
  assign out_blk.out_low  = out_low;
  assign out_free         = !out_valid || out_blk.ready;

  // Chain source: IV for the first block of a chain
  assign ch = in_blk.first_block ? iv_high : chain_high;
  assign cl = in_blk.first_block ? iv_low  : chain_low;

  // Final word reversal, then decrypt whitening (mask is zero when encrypting)
  assign result = {x_words[31:0], x_words[63:32], x_words[95:64], x_words[127:96]} ^ mask;

  assign key_mode  = (state == S_EXPAND);
  assign rnd_words = key_mode ? k_words : x_words;
  assign rk_we     = key_mode;

  // Issue the read for the round that runs next cycle; decryption walks backwards
  assign rd_step  = (state == S_ROUND) ? cnt + 1'b1 : '0;
  assign rk_raddr = (direction == sm4cbc_pkg::DIR_DECRYPT) ? LAST_ROUND - rd_step : rd_step;

  sm4cbc_ram #(
    .WIDTH (sm4cbc_pkg::WORD_W),
    .DEPTH (ROUND_COUNT)
  ) u_rk_ram (
    .clk   (clk),
    .we    (rk_we),
    .waddr (cnt),
    .wdata (nx),
    .raddr (rk_raddr),
    .rdata (rk_rdata)
  );

  sm4cbc_round u_round (
    .words     (rnd_words),
    .rk        (rk_rdata),
    .round_idx (8'(cnt)),
    .key_mode  (key_mode),
    .nx        (nx)
  );

  // Configuration writes; only taken while idle, so no clash with expansion
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high  <= '0;
      key_low   <= '0;
      iv_high   <= '0;
      iv_low    <= '0;
      direction <= sm4cbc_pkg::DIR_ENCRYPT;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        sm4cbc_pkg::REG_KEY_HIGH:  key_high  <= cfg.data;
        sm4cbc_pkg::REG_KEY_LOW:   key_low   <= cfg.data;
        sm4cbc_pkg::REG_IV_HIGH:   iv_high   <= cfg.data;
        sm4cbc_pkg::REG_IV_LOW:    iv_low    <= cfg.data;
        sm4cbc_pkg::REG_DIRECTION: direction <= cfg.data[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Control: sequencer, key-valid flag, chain and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      keys_valid <= 1'b0;
      chain_high <= '0;
      chain_low  <= '0;
      out_valid  <= 1'b0;
      cnt        <= '0;
    end else begin
      // Raise the result beat as the block finishes; retire it once taken
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_blk.ready) begin
        out_valid <= 1'b0;
      end

      // A key write invalidates the schedule
      if (cfg.valid && cfg.ready &&
          (cfg.index == sm4cbc_pkg::REG_KEY_HIGH || cfg.index == sm4cbc_pkg::REG_KEY_LOW)) begin
        keys_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_beat) begin
            cnt <= '0;
            if (direction == sm4cbc_pkg::DIR_DECRYPT) begin
              // Ciphertext in is the next chain value
              chain_high <= in_blk.in_high;
              chain_low  <= in_blk.in_low;
            end
            state <= keys_valid ? S_LOAD : S_EXPAND;
          end
        end
        S_EXPAND: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_ROUND) begin
            keys_valid <= 1'b1;
            state      <= S_LOAD;
          end
        end
        S_LOAD: begin
          // First round key read is in flight
          state <= S_ROUND;
        end
        S_ROUND: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_ROUND) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // Hold until the output register is free
          if (out_free) begin
            if (direction == sm4cbc_pkg::DIR_ENCRYPT) begin
              chain_high <= result[127:64];
              chain_low  <= result[63:0];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Data path registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_beat) begin
      k_words <= {key_high, key_low} ^ sm4cbc_pkg::FK;
      if (direction == sm4cbc_pkg::DIR_DECRYPT) begin
        x_words <= {in_blk.in_high, in_blk.in_low};
        mask    <= {ch, cl};
      end else begin
        x_words <= {in_blk.in_high ^ ch, in_blk.in_low ^ cl};
        mask    <= '0;
      end
    end
    if (state == S_EXPAND) begin
      k_words <= {k_words[95:0], nx};
    end
    if (state == S_ROUND) begin
      x_words <= {x_words[95:0], nx};
    end
    if (state == S_FINISH && out_free) begin
      out_high <= result[127:64];
      out_low  <= result[63:0];
    end
  end

endmodule

### rtl/sm4cbc_checker.sv
// ----------------------------------------------------------------------------
// sm4cbc_checker
// Port-level checks on the SM4 CBC cipher unit, bound to the top level.
// ----------------------------------------------------------------------------
module sm4cbc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_high,
  input logic [63:0] out_low
);

  logic in_accept;
  assign in_accept = in_valid && in_ready;

  // A stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_high) && $stable(out_low))
    else $error("result beat changed while stalled");

  // One block at a time: input closes right after a beat is taken
  a_one_block: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !in_ready)
    else $error("input accepted a second block while busy");

  // A new result appears only as the block returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while block still busy");

  // No result right behind an input beat
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_accept))
    else $error("result one cycle after input beat");

endmodule

bind sm4_cbc_cipher_unit sm4cbc_checker u_sm4cbc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_blk.valid),
  .in_ready  (in_blk.ready),
  .out_valid (out_blk.valid),
  .out_ready (out_blk.ready),
  .out_high  (out_blk.out_high),
  .out_low   (out_blk.out_low)
);
